// ----- rtl/core/lzk_pkg.sv -----
// Package with shared constants and types for the phrase kernel text builder.
`timescale 1ns / 1ps
package lzk_pkg;

	localparam int LEN_BITS      = 32;
	localparam int POS_BITS      = 40;
	localparam int CTX_BITS      = 16;
	localparam int SEPN_BITS     = 6;
	localparam int CMP_W         = ((LEN_BITS > CTX_BITS + 2) ? LEN_BITS : CTX_BITS + 2) + 1;
	localparam int QDEPTH        = 4;
	localparam int QADDR_BITS    = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_CONTEXT_LEN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEP_COUNT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEP_BYTE    = 2'd2;

	localparam logic [7:0] SEP_BYTE_RESET = 8'd36;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       emit_byte;
		logic       emit_seps;
		logic       limit;
	} lzk_entry_t;

endpackage

// ----- rtl/core/lzk_front.sv -----
// Front end: tracks the phrase offset and classifies each accepted byte.
`timescale 1ns / 1ps
module lzk_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           queue_full,
	input  logic [7:0]                     text_byte,
	input  logic                           phrase_first,
	input  logic [31:0]                    phrase_length,
	input  logic                           literal_phrase,
	input  logic                           final_phrase,
	input  logic [lzk_pkg::CTX_BITS-1:0]   context_length,
	output logic                           in_ready,
	output logic                           push,
	output lzk_pkg::lzk_entry_t            push_entry
);
	import lzk_pkg::*;

	logic [LEN_BITS-1:0] offset_q;
	logic [LEN_BITS-1:0] off;
	logic [LEN_BITS-1:0] len;
	logic [CMP_W-1:0]    off_x;
	logic [CMP_W-1:0]    len_x;
	logic [CMP_W-1:0]    ctx_x;
	logic [CMP_W-1:0]    short_lim;
	logic [CMP_W-1:0]    tail_start;
	logic                accept;
	logic                emit_byte;
	logic                emit_seps;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign off        = phrase_first ? '0 : offset_q;
	assign len        = phrase_length[LEN_BITS-1:0];
	assign off_x      = CMP_W'(off);
	assign len_x      = CMP_W'(len);
	assign ctx_x      = CMP_W'(context_length);
	assign short_lim  = (ctx_x << 1) + CMP_W'(2);
	assign tail_start = len_x - ctx_x;

	always_comb begin
		emit_byte = 1'b0;
		emit_seps = 1'b0;
		if (off_x < len_x) begin
			if (!final_phrase) begin
				if (literal_phrase || len_x < short_lim) begin
					emit_byte = 1'b1;
				end else if (off_x < ctx_x || off_x >= tail_start) begin
					emit_byte = 1'b1;
				end else if (off_x == ctx_x) begin
					emit_seps = 1'b1;
				end
			end else begin
				if (literal_phrase || len_x <= ctx_x) begin
					emit_byte = 1'b1;
				end else if (off_x <= ctx_x) begin
					emit_byte = 1'b1;
					emit_seps = (off_x == ctx_x);
				end
			end
		end
	end

	// Dropped bytes still advance the offset but never enter the queue.
	assign push                 = accept && (emit_byte || emit_seps);
	assign push_entry.data_byte = text_byte;
	assign push_entry.emit_byte = emit_byte;
	assign push_entry.emit_seps = emit_seps;
	assign push_entry.limit     = (off == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (accept) begin
			offset_q <= off + LEN_BITS'(1);
		end
	end

endmodule

// ----- rtl/core/lzk_queue.sv -----
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
module lzk_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lzk_pkg::lzk_entry_t  push_entry,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output lzk_pkg::lzk_entry_t  head
);
	import lzk_pkg::*;

	lzk_entry_t            mem_q [QDEPTH];
	logic [QADDR_BITS-1:0] wr_ptr_q;
	logic [QADDR_BITS-1:0] rd_ptr_q;
	logic [QADDR_BITS:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (count_q == (QADDR_BITS+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QADDR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QADDR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QADDR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QADDR_BITS+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/core/lzk_back.sv -----
// Back end: expands each queued word into result words and numbers them.
`timescale 1ns / 1ps
module lzk_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  lzk_pkg::lzk_entry_t           head,
	input  logic [lzk_pkg::SEPN_BITS-1:0] sep_count_minus_one,
	input  logic [7:0]                    sep_byte,
	input  logic                          out_ready,
	output logic                          pop,
	output logic                          out_valid,
	output logic [7:0]                    out_byte,
	output logic                          is_separator,
	output logic [lzk_pkg::POS_BITS-1:0]  kernel_position,
	output logic                          phrase_limit,
	output logic                          last_of_run
);
	import lzk_pkg::*;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 is_sep_q;
	logic [POS_BITS-1:0]  pos_q;
	logic                 limit_q;
	logic                 last_q;
	logic [POS_BITS-1:0]  kcount_q;
	logic                 byte_done_q;
	logic [SEPN_BITS-1:0] sep_cnt_q;
	logic                 load;
	logic                 send_byte;
	logic                 last_sep;
	logic                 last_now;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign send_byte = head.emit_byte && !byte_done_q;
	assign last_sep  = (sep_cnt_q == sep_count_minus_one);
	assign last_now  = send_byte ? !head.emit_seps : last_sep;
	assign pop       = load && last_now;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= send_byte ? head.data_byte : sep_byte;
			is_sep_q   <= !send_byte;
			pos_q      <= kcount_q;
			// A separator carries the limit only if it opens the phrase.
			limit_q    <= send_byte ? head.limit
			                        : (head.limit && !head.emit_byte && sep_cnt_q == '0);
			last_q     <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kcount_q    <= '0;
			byte_done_q <= 1'b0;
			sep_cnt_q   <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				kcount_q    <= kcount_q + POS_BITS'(1);
				if (last_now) begin
					byte_done_q <= 1'b0;
					sep_cnt_q   <= '0;
				end else if (send_byte) begin
					byte_done_q <= 1'b1;
				end else begin
					sep_cnt_q <= sep_cnt_q + SEPN_BITS'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign is_separator    = is_sep_q;
	assign kernel_position = pos_q;
	assign phrase_limit    = limit_q;
	assign last_of_run     = last_q;

endmodule

// ----- rtl/core/lz_phrase_kernel_text_builder.sv -----
// Top level of the phrase kernel text builder.
// Input channel (in_valid/in_ready) takes one text byte per word with its phrase tags;
// output channel (out_valid/out_ready) delivers kernel text words in order.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is idle:
// index 0 is the context length, 1 the separator count minus one, 2 the separator byte.
// Each accepted byte is classified in the cycle it is taken and, unless it is dropped,
// placed in a four-word queue; the back end turns each queued word into its results.
// An accepted byte is written into the queue and then registered in the back-end output register.
// Throughput is one result word per cycle while the receiver is ready and the queue holds
// words: a plain byte gives one word, and a separator burst gives K+1 words (K+2 with a
// final phrase's byte) while the front keeps filling the queue. Dropped bytes never reach the back end.
// When the receiver stalls, the output register holds its word, the queue fills
// and in_ready falls once it is full.
// Reset clears the offset and position counters, empties the queue and sets the
// registers to their defaults (separator byte 36).
`timescale 1ns / 1ps
module lz_phrase_kernel_text_builder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lzk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [lzk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         text_byte,
	input  logic                               phrase_first,
	input  logic [31:0]                        phrase_length,
	input  logic                               literal_phrase,
	input  logic                               final_phrase,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         out_byte,
	output logic                               is_separator,
	output logic [lzk_pkg::POS_BITS-1:0]       kernel_position,
	output logic                               phrase_limit,
	output logic                               last_of_run
);
	import lzk_pkg::*;

	logic [CTX_BITS-1:0]  context_len_q;
	logic [SEPN_BITS-1:0] sep_count_q;
	logic [7:0]           sep_byte_q;
	logic                 queue_full;
	logic                 push;
	lzk_entry_t           push_entry;
	logic                 pop;
	logic                 head_valid;
	lzk_entry_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			context_len_q <= '0;
			sep_count_q   <= '0;
			sep_byte_q    <= SEP_BYTE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTEXT_LEN: context_len_q <= cfg_data[CTX_BITS-1:0];
				REG_SEP_COUNT:   sep_count_q   <= cfg_data[SEPN_BITS-1:0];
				REG_SEP_BYTE:    sep_byte_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lzk_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.queue_full     (queue_full),
		.text_byte      (text_byte),
		.phrase_first   (phrase_first),
		.phrase_length  (phrase_length),
		.literal_phrase (literal_phrase),
		.final_phrase   (final_phrase),
		.context_length (context_len_q),
		.in_ready       (in_ready),
		.push           (push),
		.push_entry     (push_entry)
	);

	lzk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	lzk_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.head_valid          (head_valid),
		.head                (head),
		.sep_count_minus_one (sep_count_q),
		.sep_byte            (sep_byte_q),
		.out_ready           (out_ready),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_byte            (out_byte),
		.is_separator        (is_separator),
		.kernel_position     (kernel_position),
		.phrase_limit        (phrase_limit),
		.last_of_run         (last_of_run)
	);

	// A separator word always carries the configured separator value.
	a_sep_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_separator |-> out_byte == sep_byte_q)
		else $error("separator word carries a wrong byte");

	// A run that is not finished continues in the very next cycle.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("result run broken off");

	// Successive result words take successive kernel positions.
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run
		|=> kernel_position == $past(kernel_position) + POS_BITS'(1))
		else $error("kernel position did not advance by one");

	// The queue is never popped while empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

// ----- dv/lz_phrase_kernel_text_builder_tb.sv -----
// Self-checking testbench for the phrase kernel text builder, with its own kernel text predictor.
`timescale 1ns / 1ps
module lz_phrase_kernel_text_builder_tb;
	import lzk_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [7:0]               text_byte = '0;
	logic                     phrase_first = 1'b0;
	logic [31:0]              phrase_length = '0;
	logic                     literal_phrase = 1'b0;
	logic                     final_phrase = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [7:0]               out_byte;
	logic                     is_separator;
	logic [POS_BITS-1:0]      kernel_position;
	logic                     phrase_limit;
	logic                     last_of_run;

	typedef struct packed {
		logic [7:0]          data;
		logic                sep;
		logic [POS_BITS-1:0] pos;
		logic                limit;
		logic                tail;
	} kernel_word_t;

	// Predicts the kernel text words for each accepted text byte and checks them in order.
	class kernel_text_predictor;
		logic [15:0]         ctx_len;
		logic [5:0]          sep_count_m1;
		logic [7:0]          sep_value;
		logic [31:0]         phrase_offset;
		logic [POS_BITS-1:0] next_position;
		kernel_word_t        expected_words[$];
		int                  mismatches;

		function new();
			ctx_len = '0;
			sep_count_m1 = '0;
			sep_value = SEP_BYTE_RESET;
			phrase_offset = '0;
			next_position = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_CONTEXT_LEN: ctx_len = value[15:0];
				REG_SEP_COUNT:   sep_count_m1 = value[5:0];
				REG_SEP_BYTE:    sep_value = value[7:0];
				default: ;
			endcase
		endfunction

		function void push_word(logic [7:0] data, logic sep, logic limit, logic tail);
			kernel_word_t w;
			w.data = data;
			w.sep = sep;
			w.pos = next_position;
			w.limit = limit;
			w.tail = tail;
			expected_words.push_back(w);
			next_position = next_position + 1'b1;
		endfunction

		// Returns the number of words this text byte is expected to produce.
		function int take_text_byte(logic [7:0] data, logic first, logic [31:0] len,
				logic lit, logic fin);
			logic [31:0] off;
			logic [33:0] long_floor;
			logic        keep;
			logic        burst;
			int          total;
			int          n;
			int          i;
			off = first ? 32'd0 : phrase_offset;
			phrase_offset = off + 32'd1;
			long_floor = {17'd0, ctx_len, 1'b0} + 34'd2;
			keep = 1'b0;
			burst = 1'b0;
			if (off < len) begin
				if (!fin) begin
					if (lit || {2'b00, len} < long_floor)
						keep = 1'b1;
					else if (off < {16'd0, ctx_len} || off >= len - {16'd0, ctx_len})
						keep = 1'b1;
					else if (off == {16'd0, ctx_len})
						burst = 1'b1;
				end else begin
					if (lit || len <= {16'd0, ctx_len}) begin
						keep = 1'b1;
					end else if (off <= {16'd0, ctx_len}) begin
						keep = 1'b1;
						burst = (off == {16'd0, ctx_len});
					end
				end
			end
			total = (keep ? 1 : 0) + (burst ? int'(sep_count_m1) + 1 : 0);
			n = 0;
			if (keep) begin
				push_word(data, 1'b0, off == 32'd0, n == total - 1);
				n++;
			end
			if (burst) begin
				for (i = 0; i <= int'(sep_count_m1); i++) begin
					push_word(sep_value, 1'b1, n == 0 && off == 32'd0, n == total - 1);
					n++;
				end
			end
			return total;
		endfunction

		function void check_kernel_word(logic [7:0] data, logic sep, logic [POS_BITS-1:0] pos,
				logic limit, logic tail);
			kernel_word_t w;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected kernel word byte=%h pos=%0d", $time, data, pos);
				mismatches++;
				return;
			end
			w = expected_words.pop_front();
			if (data !== w.data) begin
				$display("%0t: out_byte expected %h actual %h", $time, w.data, data);
				mismatches++;
			end
			if (sep !== w.sep) begin
				$display("%0t: is_separator expected %b actual %b", $time, w.sep, sep);
				mismatches++;
			end
			if (pos !== w.pos) begin
				$display("%0t: kernel_position expected %0d actual %0d", $time, w.pos, pos);
				mismatches++;
			end
			if (limit !== w.limit) begin
				$display("%0t: phrase_limit expected %b actual %b", $time, w.limit, limit);
				mismatches++;
			end
			if (tail !== w.tail) begin
				$display("%0t: last_of_run expected %b actual %b", $time, w.tail, tail);
				mismatches++;
			end
		endfunction
	endclass

	kernel_text_predictor board = new();
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int sent_items = 0;

	lz_phrase_kernel_text_builder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.text_byte(text_byte), .phrase_first(phrase_first), .phrase_length(phrase_length),
		.literal_phrase(literal_phrase), .final_phrase(final_phrase),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .is_separator(is_separator), .kernel_position(kernel_position),
		.phrase_limit(phrase_limit), .last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_word(input logic [7:0] data, input logic first, input logic [31:0] len,
			input logic lit, input logic fin);
		in_valid <= 1'b1;
		text_byte <= data;
		phrase_first <= first;
		phrase_length <= len;
		literal_phrase <= lit;
		final_phrase <= fin;
		do @(posedge clk); while (!in_ready);
		void'(board.take_text_byte(data, first, len, lit, fin));
		sent_items++;
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Waits for every expected word, then lets the output fall idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_words.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] ctx, input logic [5:0] k,
			input logic [7:0] sepv);
		cfg_we <= 1'b1;
		cfg_index <= REG_CONTEXT_LEN;
		cfg_data <= ctx;
		@(posedge clk);
		board.set_reg(REG_CONTEXT_LEN, ctx);
		cfg_index <= REG_SEP_COUNT;
		cfg_data <= {10'd0, k};
		@(posedge clk);
		board.set_reg(REG_SEP_COUNT, {10'd0, k});
		cfg_index <= REG_SEP_BYTE;
		cfg_data <= {8'd0, sepv};
		@(posedge clk);
		board.set_reg(REG_SEP_BYTE, {8'd0, sepv});
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed phrases around the length boundaries, some with broken tagging.
	task automatic send_phrase(input logic [15:0] ctx);
		logic [31:0] len;
		logic [31:0] this_len;
		logic        lit;
		logic        fin;
		logic        noisy;
		logic        first;
		logic        this_lit;
		logic        this_fin;
		int          count;
		int          pick;
		int          i;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			len = $urandom_range(1, (ctx < 16) ? 2 * ctx + 6 : 30);
		else if (pick < 85)
			case ($urandom_range(0, 3))
				0: len = 32'(ctx);
				1: len = ctx + 1;
				2: len = 2 * ctx + 1;
				default: len = 2 * ctx + 2;
			endcase
		else
			len = $urandom();
		lit = $urandom_range(0, 99) < 25;
		fin = $urandom_range(0, 99) < 30;
		noisy = $urandom_range(0, 99) < 20;
		count = (len >= 1 && len <= 40) ? int'(len) : $urandom_range(1, 8);
		if (noisy)
			count += $urandom_range(0, 3);
		for (i = 0; i < count; i++) begin
			first = (i == 0) && !(noisy && $urandom_range(0, 3) == 0);
			this_len = len;
			this_lit = lit;
			this_fin = fin;
			if (noisy && $urandom_range(0, 7) == 0) this_lit = ~lit;
			if (noisy && $urandom_range(0, 7) == 0) this_fin = ~fin;
			if (noisy && $urandom_range(0, 7) == 0) this_len = $urandom_range(0, 50);
			send_word(8'($urandom_range(0, 255)), first, this_len, this_lit, this_fin);
			maybe_gap();
		end
	endtask

	// Output side: checks each accepted word and stalls at random or for one long hold-off.
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_kernel_word(out_byte, is_separator, kernel_position, phrase_limit,
					last_of_run);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 20);
			end
		end
	end

	initial begin
		logic [15:0] ctx;
		int          phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no context, a single separator of the default value.
		send_word(8'h00, 1'b1, 32'd1, 1'b0, 1'b0);
		send_word(8'hFF, 1'b1, 32'd3, 1'b0, 1'b0);
		send_word(8'h11, 1'b0, 32'd3, 1'b0, 1'b0);
		send_word(8'h22, 1'b0, 32'd3, 1'b0, 1'b0);
		send_word(8'h33, 1'b0, 32'd3, 1'b0, 1'b0);
		send_word(8'h44, 1'b1, 32'd0, 1'b0, 1'b0);
		send_word(8'h55, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		settle();

		load_settings(16'd1, 6'd1, 8'hA5);
		// A non-final phrase exactly at the long threshold: head, burst, dropped byte, tail.
		send_word(8'h01, 1'b1, 32'd4, 1'b0, 1'b0);
		send_word(8'h02, 1'b0, 32'd4, 1'b0, 1'b0);
		send_word(8'h03, 1'b0, 32'd4, 1'b0, 1'b0);
		send_word(8'h04, 1'b0, 32'd4, 1'b0, 1'b0);
		send_word(8'h80, 1'b1, 32'd3, 1'b1, 1'b0);
		send_word(8'h81, 1'b0, 32'd3, 1'b1, 1'b0);
		send_word(8'h82, 1'b0, 32'd3, 1'b1, 1'b0);
		send_word(8'h90, 1'b1, 32'd1, 1'b0, 1'b1);
		// A long final phrase: the burst follows the byte at the context offset.
		send_word(8'hA0, 1'b1, 32'd5, 1'b0, 1'b1);
		send_word(8'hA1, 1'b0, 32'd5, 1'b0, 1'b1);
		send_word(8'hA2, 1'b0, 32'd5, 1'b0, 1'b1);
		send_word(8'hA3, 1'b0, 32'd5, 1'b0, 1'b1);
		// Tags that change within a phrase are taken per byte.
		send_word(8'hB0, 1'b1, 32'd10, 1'b0, 1'b0);
		send_word(8'hB1, 1'b0, 32'd10, 1'b1, 1'b0);
		send_word(8'hC0, 1'b1, 32'd2, 1'b1, 1'b1);
		send_word(8'hC1, 1'b0, 32'd2, 1'b1, 1'b1);
		settle();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: ctx = 16'd2;
				1: ctx = 16'd0;
				2: ctx = 16'hFFFF;
				3: ctx = 16'($urandom_range(1, 5));
				default: ctx = 16'($urandom_range(0, 65535));
			endcase
			case (phase)
				0: load_settings(ctx, 6'd3, 8'($urandom_range(0, 255)));
				1: load_settings(ctx, 6'd62, 8'hFF);
				2: load_settings(ctx, 6'd0, 8'h00);
				default: load_settings(ctx, 6'($urandom_range(0, 62)),
					8'($urandom_range(0, 255)));
			endcase
			calm = (phase == 1);
			if (phase == 0)
				hold_request = 1'b1;
			sent_items = 0;
			while (sent_items < 56)
				send_phrase(ctx);
			settle();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.expected_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- lz_phrase_kernel_text_builder.f -----
rtl/core/lzk_pkg.sv
rtl/core/lzk_front.sv
rtl/core/lzk_queue.sv
rtl/core/lzk_back.sv
rtl/core/lz_phrase_kernel_text_builder.sv
dv/lz_phrase_kernel_text_builder_tb.sv
